>>> rtl/core/tms_pkg.sv
// Shared types and codes for the Turing machine stepper.
package tms_pkg;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_FIN
   } seq_state_type;

   localparam logic [1:0] ACT_LOAD = 2'd0;
   localparam logic [1:0] ACT_STEP = 2'd1;
   localparam logic [1:0] ACT_READ = 2'd2;

   localparam logic [1:0] FAULT_NONE    = 2'd0;
   localparam logic [1:0] FAULT_NOMATCH = 2'd1;
   localparam logic [1:0] FAULT_EDGE    = 2'd2;

   localparam logic [1:0] MOVE_RIGHT = 2'b01;
   localparam logic [1:0] MOVE_LEFT  = 2'b11;

   localparam logic [7:0] CHAR_ZERO = 8'd48;

   typedef struct packed {
      logic [1:0] move;
      logic       wr_sym;
      logic [7:0] next_state;
      logic       sym;
      logic [7:0] state;
   } rule_type;

   typedef struct packed {
      logic written;
      logic sym;
   } cell_type;

endpackage

>>> rtl/core/tms_rule_ram.sv
// Rule table: one write port, one registered read port.
module tms_rule_ram #(
   parameter int MAX_RULES = 64,
   localparam int RW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [RW-1:0]     wr_addr,
   input  tms_pkg::rule_type wr_rule,
   input  logic              rd_en,
   input  logic [RW-1:0]     rd_addr,
   output tms_pkg::rule_type rd_rule
);
   import tms_pkg::*;

   rule_type rule_mem [MAX_RULES];
   rule_type rd_rule_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rule_mem[wr_addr] <= wr_rule;
      end
      if (rd_en) begin
         rd_rule_ff <= rule_mem[rd_addr];
      end
   end

   assign rd_rule = rd_rule_ff;

endmodule

>>> rtl/core/tms_tape_ram.sv
// Tape store with a clearing sweep after reset.
module tms_tape_ram #(
   parameter int TAPE_CELLS = 4096,
   localparam int HW = $clog2(TAPE_CELLS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [HW-1:0]     rd_addr,
   output tms_pkg::cell_type rd_cell,
   input  logic              wr_en,
   input  logic [HW-1:0]     wr_addr,
   input  tms_pkg::cell_type wr_cell,
   output logic              busy
);
   import tms_pkg::*;

   cell_type      tape_mem [TAPE_CELLS];
   cell_type      rd_cell_ff;
   logic          busy_ff, busy_in;
   logic [HW-1:0] clr_addr_ff, clr_addr_in;
   logic          mem_we;
   logic [HW-1:0] mem_wa;
   cell_type      mem_wd;

   always_comb begin
      busy_in     = busy_ff;
      clr_addr_in = clr_addr_ff;
      if (busy_ff) begin
         clr_addr_in = clr_addr_ff + HW'(1);
         if (clr_addr_ff == HW'(TAPE_CELLS - 1)) begin
            busy_in = 1'b0;
         end
      end
      // sweep owns the write port until the last cell is cleared
      mem_we = busy_ff || wr_en;
      mem_wa = busy_ff ? clr_addr_ff : wr_addr;
      mem_wd = busy_ff ? cell_type'('0) : wr_cell;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         busy_ff     <= busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tape_mem[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rd_cell_ff <= tape_mem[rd_addr];
      end
   end

   assign rd_cell = rd_cell_ff;
   assign busy    = busy_ff;

endmodule

>>> rtl/core/turing_machine_stepper.sv
// Turing machine stepper: sequencer, machine registers and result register.
// Every action but a step goes from accept straight to the result stage, as does a step on a halted machine
// or with no rules to scan; any other step first scans rule slots until one fires or the last slot faults.
// The rule scan reads one slot per cycle from the rule memory, up to min(rule_count, MAX_RULES).
// A new item is taken only once the sequencer is back in idle, after the previous result is registered.
// After reset the tape is swept clear with req_stall held high.
module turing_machine_stepper #(
   parameter int TAPE_CELLS = 4096,
   parameter int MAX_RULES  = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [6:0]        csr_wr_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_action,
   input  logic [5:0]        req_rule_slot,
   input  logic [7:0]        req_rule_state,
   input  logic              req_rule_symbol,
   input  logic [7:0]        req_rule_next_state,
   input  logic              req_rule_write,
   input  logic signed [1:0] req_rule_move,
   input  logic [11:0]       req_read_offset,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_halted,
   output logic [1:0]        rsp_fault,
   output logic [7:0]        rsp_current_state,
   output logic [31:0]       rsp_step_count,
   output logic [11:0]      rsp_head_position,
   output logic [11:0]       rsp_low_mark,
   output logic [7:0]        rsp_cell_char
);
   import tms_pkg::*;

   localparam int HW = $clog2(TAPE_CELLS);
   localparam int RW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
   localparam int LW = $clog2(MAX_RULES + 1);
   localparam int AW = ((HW > 12) ? HW : 12) + 1;

   seq_state_type seq_ff, seq_in;
   logic [7:0]    state_ff, state_in;
   logic [HW-1:0] head_ff, head_in;
   logic [HW-1:0] low_ff, low_in;
   logic [31:0]   steps_ff, steps_in;
   logic [1:0]    fault_ff, fault_in;
   logic [6:0]    rule_count_ff, rule_count_in;
   logic [1:0]    action_ff, action_in;
   logic          oob_ff, oob_in;
   logic [RW-1:0] idx_ff, idx_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_halted_ff, rsp_halted_in;
   logic [1:0]    rsp_fault_ff, rsp_fault_in;
   logic [7:0]    rsp_state_ff, rsp_state_in;
   logic [31:0]   rsp_steps_ff, rsp_steps_in;
   logic [11:0]   rsp_head_ff, rsp_head_in;
   logic [11:0]   rsp_low_ff, rsp_low_in;
   logic [7:0]    rsp_char_ff, rsp_char_in;

   logic          req_accept;
   logic          rsp_load;
   logic          halted;
   logic          slot_ok;
   logic [LW-1:0] limit;
   logic          scan_last;
   logic          rule_hit;
   logic [AW-1:0] read_sum;
   logic          read_oob;
   logic [HW-1:0] head_nx;

   logic          rule_we, rule_re;
   logic [RW-1:0] rule_ra;
   rule_type      rule_wd, rule_rd;
   logic          tape_re, tape_we, tape_busy;
   logic [HW-1:0] tape_ra;
   cell_type      tape_rd, tape_wd;

   tms_rule_ram #(.MAX_RULES(MAX_RULES)) u_rule_ram (
      .clock   (clock),
      .wr_en   (rule_we),
      .wr_addr (RW'(req_rule_slot)),
      .wr_rule (rule_wd),
      .rd_en   (rule_re),
      .rd_addr (rule_ra),
      .rd_rule (rule_rd)
   );

   tms_tape_ram #(.TAPE_CELLS(TAPE_CELLS)) u_tape_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (tape_re),
      .rd_addr (tape_ra),
      .rd_cell (tape_rd),
      .wr_en   (tape_we),
      .wr_addr (head_ff),
      .wr_cell (tape_wd),
      .busy    (tape_busy)
   );

   assign req_stall  = (seq_ff != SEQ_IDLE) || tape_busy;
   assign req_accept = req_valid && !req_stall;
   assign halted     = (state_ff == 8'd0) || (fault_ff != FAULT_NONE);
   assign slot_ok    = 32'(req_rule_slot) < MAX_RULES;
   assign limit      = (32'(rule_count_ff) > MAX_RULES) ? LW'(MAX_RULES) : LW'(rule_count_ff);
   assign scan_last  = (LW'(idx_ff) + LW'(1)) == limit;
   assign rule_hit   = (rule_rd.state == state_ff) && (rule_rd.sym == tape_rd.sym);
   assign read_sum   = AW'(low_ff) + AW'(req_read_offset);
   assign read_oob   = read_sum >= AW'(TAPE_CELLS);

   assign rule_wd.state      = req_rule_state;
   assign rule_wd.sym        = req_rule_symbol;
   assign rule_wd.next_state = req_rule_next_state;
   assign rule_wd.wr_sym     = req_rule_write;
   assign rule_wd.move       = req_rule_move;

   assign tape_wd.written = 1'b1;
   assign tape_wd.sym     = rule_rd.wr_sym;

   always_comb begin
      seq_in        = seq_ff;
      state_in      = state_ff;
      head_in       = head_ff;
      low_in        = low_ff;
      steps_in      = steps_ff;
      fault_in      = fault_ff;
      action_in     = action_ff;
      oob_in        = oob_ff;
      idx_in        = idx_ff;
      rule_count_in = csr_wr_en ? csr_wr_data : rule_count_ff;
      head_nx       = head_ff;
      rule_we       = 1'b0;
      rule_re       = 1'b0;
      rule_ra       = '0;
      tape_re       = 1'b0;
      tape_ra       = head_ff;
      tape_we       = 1'b0;
      rsp_load      = 1'b0;
      case (seq_ff)
         SEQ_IDLE: begin
            if (req_accept) begin
               action_in = req_action;
               oob_in    = read_oob;
               case (req_action)
                  ACT_LOAD: begin
                     rule_we = slot_ok;
                     seq_in  = SEQ_FIN;
                  end
                  ACT_STEP: begin
                     // fetch the cell under the head and the first slot together
                     tape_re = 1'b1;
                     rule_re = 1'b1;
                     idx_in  = '0;
                     if (halted) begin
                        seq_in = SEQ_FIN;
                     end else if (limit == '0) begin
                        fault_in = FAULT_NOMATCH;
                        seq_in   = SEQ_FIN;
                     end else begin
                        seq_in = SEQ_SCAN;
                     end
                  end
                  ACT_READ: begin
                     tape_re = !read_oob;
                     tape_ra = read_sum[HW-1:0];
                     seq_in  = SEQ_FIN;
                  end
                  default: begin
                     seq_in = SEQ_FIN;
                  end
               endcase
            end
         end
         SEQ_SCAN: begin
            if (rule_hit) begin
               tape_we  = 1'b1;
               state_in = rule_rd.next_state;
               steps_in = (steps_ff == 32'hFFFF_FFFF) ? steps_ff : steps_ff + 32'd1;
               case (rule_rd.move)
                  MOVE_RIGHT: begin
                     if (head_ff == HW'(TAPE_CELLS - 1)) begin
                        fault_in = FAULT_EDGE;
                     end else begin
                        head_nx = head_ff + HW'(1);
                     end
                  end
                  MOVE_LEFT: begin
                     if (head_ff == '0) begin
                        fault_in = FAULT_EDGE;
                     end else begin
                        head_nx = head_ff - HW'(1);
                     end
                  end
                  default: begin
                     head_nx = head_ff;
                  end
               endcase
               head_in = head_nx;
               if (head_nx < low_ff) begin
                  low_in = head_nx;
               end
               seq_in = SEQ_FIN;
            end else if (scan_last) begin
               fault_in = FAULT_NOMATCH;
               seq_in   = SEQ_FIN;
            end else begin
               idx_in  = idx_ff + RW'(1);
               rule_re = 1'b1;
               rule_ra = idx_ff + RW'(1);
            end
         end
         SEQ_FIN: begin
            // hold until the result register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               seq_in   = SEQ_IDLE;
            end
         end
         default: begin
            seq_in = SEQ_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_load || (rsp_valid_ff && rsp_stall);
      rsp_halted_in = rsp_halted_ff;
      rsp_fault_in  = rsp_fault_ff;
      rsp_state_in  = rsp_state_ff;
      rsp_steps_in  = rsp_steps_ff;
      rsp_head_in   = rsp_head_ff;
      rsp_low_in    = rsp_low_ff;
      rsp_char_in   = rsp_char_ff;
      if (rsp_load) begin
         rsp_halted_in = halted;
         rsp_fault_in  = fault_ff;
         rsp_state_in  = state_ff;
         rsp_steps_in  = steps_ff;
         rsp_head_in   = 12'(head_ff);
         rsp_low_in    = 12'(low_ff);
         if ((action_ff == ACT_READ) && !oob_ff && tape_rd.written) begin
            rsp_char_in = CHAR_ZERO | {7'd0, tape_rd.sym};
         end else begin
            rsp_char_in = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff        <= SEQ_IDLE;
         state_ff      <= 8'd1;
         head_ff       <= HW'(TAPE_CELLS / 2);
         low_ff        <= HW'(TAPE_CELLS / 2);
         steps_ff      <= 32'd0;
         fault_ff      <= FAULT_NONE;
         rule_count_ff <= 7'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         seq_ff        <= seq_in;
         state_ff      <= state_in;
         head_ff       <= head_in;
         low_ff        <= low_in;
         steps_ff      <= steps_in;
         fault_ff      <= fault_in;
         rule_count_ff <= rule_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      oob_ff        <= oob_in;
      idx_ff        <= idx_in;
      rsp_halted_ff <= rsp_halted_in;
      rsp_fault_ff  <= rsp_fault_in;
      rsp_state_ff  <= rsp_state_in;
      rsp_steps_ff  <= rsp_steps_in;
      rsp_head_ff   <= rsp_head_in;
      rsp_low_ff    <= rsp_low_in;
      rsp_char_ff   <= rsp_char_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_halted        = rsp_halted_ff;
   assign rsp_fault         = rsp_fault_ff;
   assign rsp_current_state = rsp_state_ff;
   assign rsp_step_count    = rsp_steps_ff;
   assign rsp_head_position = rsp_head_ff;
   assign rsp_low_mark      = rsp_low_ff;
   assign rsp_cell_char     = rsp_char_ff;

   a_low_not_right_of_head : assert property (@(posedge clock) disable iff (reset)
      low_ff <= head_ff)
      else $error("low-water mark lies right of the head");

   a_fault_code_known : assert property (@(posedge clock) disable iff (reset)
      fault_ff != 2'd3)
      else $error("unknown fault code");

   a_halted_step_frozen : assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_action == ACT_STEP) && halted)
      |=> ($stable(steps_ff) && $stable(head_ff) && $stable(state_ff)))
      else $error("step on a halted machine changed it");

   a_fin_holds_on_stall : assert property (@(posedge clock) disable iff (reset)
      ((seq_ff == SEQ_FIN) && rsp_valid_ff && rsp_stall) |=> (seq_ff == SEQ_FIN))
      else $error("result dropped while the output beat was stalled");

endmodule

>>> tb/sv/turing_machine_stepper_tb.sv
// Self-checking testbench for the Turing machine stepper: queued driver, predictor and monitor.
module turing_machine_stepper_tb;
   import tms_pkg::*;

   localparam int TAPE_CELLS   = 4096;
   localparam int MAX_RULES    = 64;
   localparam int GUARD_RULES  = 10;
   localparam int PHASE_ITEMS  = 110;
   localparam int SETTLE_TICKS = 80;
   localparam int HOLD_AT      = 200;
   localparam int HOLD_TICKS   = 500;
   localparam int CYCLE_LIMIT  = 1000000;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam logic [1:0] MOVE_STAY  = 2'b00;
   localparam logic [1:0] MOVE_ODD   = 2'b10;

   typedef struct {
      logic [1:0]  action;
      logic [5:0]  slot;
      logic [7:0]  rstate;
      logic        rsym;
      logic [7:0]  rnext;
      logic        rwrite;
      logic [1:0]  rmove;
      logic [11:0] offset;
   } tm_item_type;

   typedef struct {
      logic        halted;
      logic [1:0]  fault;
      logic [7:0]  state;
      logic [31:0] steps;
      logic [11:0] head;
      logic [11:0] low;
      logic [7:0]  ch;
   } tm_status_type;

   typedef enum {END_HALT, END_NOMATCH, END_EDGE} ending_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [6:0] csr_wr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_action = '0;
   logic [5:0] req_rule_slot = '0;
   logic [7:0] req_rule_state = '0;
   logic req_rule_symbol = 1'b0;
   logic [7:0] req_rule_next_state = '0;
   logic req_rule_write = 1'b0;
   logic signed [1:0] req_rule_move = '0;
   logic [11:0] req_read_offset = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_halted;
   logic [1:0] rsp_fault;
   logic [7:0] rsp_current_state;
   logic [31:0] rsp_step_count;
   logic [11:0] rsp_head_position;
   logic [11:0] rsp_low_mark;
   logic [7:0] rsp_cell_char;

   turing_machine_stepper #(
      .TAPE_CELLS(TAPE_CELLS),
      .MAX_RULES(MAX_RULES)
   ) uut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_rule_slot(req_rule_slot),
      .req_rule_state(req_rule_state),
      .req_rule_symbol(req_rule_symbol),
      .req_rule_next_state(req_rule_next_state),
      .req_rule_write(req_rule_write),
      .req_rule_move(req_rule_move),
      .req_read_offset(req_read_offset),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_halted(rsp_halted),
      .rsp_fault(rsp_fault),
      .rsp_current_state(rsp_current_state),
      .rsp_step_count(rsp_step_count),
      .rsp_head_position(rsp_head_position),
      .rsp_low_mark(rsp_low_mark),
      .rsp_cell_char(rsp_cell_char)
   );

   always #1 clock = ~clock;

   // predictor copy of the machine
   rule_type    tm_rules [MAX_RULES];
   cell_type    tm_tape [TAPE_CELLS];
   logic [7:0]  tm_state;
   logic [11:0] tm_head;
   logic [11:0] tm_low;
   logic [31:0] tm_steps;
   logic [1:0]  tm_fault;
   logic [6:0]  tm_rule_count;

   tm_item_type   queued_actions [$];
   tm_status_type predicted_status [$];
   tm_item_type   shown_item;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int errors = 0;
   int results_seen = 0;
   int cycle_count = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   // states the machine may reach while running; every random or guard rule on one of them leads back into the set
   function automatic logic [7:0] live_state(input int k);
      case (k)
         0: return 8'h01;
         1: return 8'h2A;
         2: return 8'hD5;
         3: return 8'hFE;
         default: return 8'hFF;
      endcase
   endfunction

   function automatic bit is_live(input logic [7:0] s);
      for (int k = 0; k < 5; k++) if (live_state(k) == s) return 1'b1;
      return 1'b0;
   endfunction

   function automatic tm_status_type machine_advance(input tm_item_type it);
      tm_status_type res;
      rule_type r;
      logic [12:0] idx;
      int limit;
      int hit;
      res.ch = 8'd0;
      hit = -1;
      if (it.action == ACT_LOAD) begin
         tm_rules[it.slot] = '{move: it.rmove, wr_sym: it.rwrite, next_state: it.rnext,
                               sym: it.rsym, state: it.rstate};
      end else if (it.action == ACT_STEP) begin
         if (tm_state != 8'd0 && tm_fault == FAULT_NONE) begin
            limit = (tm_rule_count > MAX_RULES) ? MAX_RULES : int'(tm_rule_count);
            for (int i = 0; i < limit; i++) begin
               if (hit < 0 && tm_rules[i].state == tm_state
                   && tm_rules[i].sym == tm_tape[tm_head].sym)
                  hit = i;
            end
            if (hit < 0) begin
               tm_fault = FAULT_NOMATCH;
            end else begin
               r = tm_rules[hit];
               tm_tape[tm_head] = '{written: 1'b1, sym: r.wr_sym};
               tm_state = r.next_state;
               if (tm_steps != 32'hFFFF_FFFF) tm_steps++;
               if (r.move == MOVE_RIGHT) begin
                  if (tm_head == TAPE_CELLS - 1) tm_fault = FAULT_EDGE;
                  else tm_head++;
               end else if (r.move == MOVE_LEFT) begin
                  if (tm_head == 0) tm_fault = FAULT_EDGE;
                  else tm_head--;
               end
               if (tm_head < tm_low) tm_low = tm_head;
            end
         end
      end else if (it.action == ACT_READ) begin
         idx = {1'b0, tm_low} + {1'b0, it.offset};
         if (idx < TAPE_CELLS && tm_tape[idx[11:0]].written)
            res.ch = CHAR_ZERO | {7'd0, tm_tape[idx[11:0]].sym};
      end
      res.halted = (tm_state == 8'd0 || tm_fault != FAULT_NONE);
      res.fault = tm_fault;
      res.state = tm_state;
      res.steps = tm_steps;
      res.head = tm_head;
      res.low = tm_low;
      return res;
   endfunction

   function automatic tm_item_type noise_item();
      tm_item_type it;
      it.action = 2'($urandom_range(0, 3));
      it.slot = 6'($urandom_range(0, 63));
      it.rstate = 8'($urandom_range(0, 255));
      it.rsym = 1'($urandom_range(0, 1));
      it.rnext = 8'($urandom_range(0, 255));
      it.rwrite = 1'($urandom_range(0, 1));
      it.rmove = 2'($urandom_range(0, 3));
      it.offset = 12'($urandom_range(0, 4095));
      return it;
   endfunction

   // guard slot k of the block covers one live state and one symbol
   function automatic tm_item_type guard_load(input int slot, input int base);
      tm_item_type it;
      int k;
      it = noise_item();
      k = slot - base;
      it.action = ACT_LOAD;
      it.slot = slot[5:0];
      it.rstate = live_state(k / 2);
      it.rsym = k[0];
      it.rnext = live_state($urandom_range(0, 4));
      return it;
   endfunction

   function automatic tm_item_type random_load(input int slot, input int base);
      tm_item_type it;
      if (slot >= base && slot < base + GUARD_RULES) return guard_load(slot, base);
      it = noise_item();
      it.action = ACT_LOAD;
      it.slot = slot[5:0];
      if ($urandom_range(0, 99) < 60) it.rstate = live_state($urandom_range(0, 4));
      if (is_live(it.rstate)) it.rnext = live_state($urandom_range(0, 4));
      return it;
   endfunction

   function automatic tm_item_type random_item(input int base);
      tm_item_type it;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick >= 50 && pick < 72) return random_load($urandom_range(0, 63), base);
      it = noise_item();
      if (pick < 50) begin
         it.action = ACT_STEP;
      end else if (pick < 95) begin
         it.action = ACT_READ;
         if ($urandom_range(0, 99) < 70) it.offset = 12'($urandom_range(0, 80));
      end else begin
         it.action = ACT_UNUSED;
      end
      return it;
   endfunction

   function automatic tm_item_type make_item(input logic [1:0] act, input int slot,
                                             input logic [7:0] st, input logic sym,
                                             input logic [7:0] nxt, input logic wr,
                                             input logic [1:0] mv, input int off);
      tm_item_type it;
      it.action = act;
      it.slot = slot[5:0];
      it.rstate = st;
      it.rsym = sym;
      it.rnext = nxt;
      it.rwrite = wr;
      it.rmove = mv;
      it.offset = off[11:0];
      return it;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s expected %0d actual %0d", name, want, got);
         errors++;
      end
   endfunction

   task automatic write_rule_count(input int n);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= n[6:0];
      tm_rule_count = n[6:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // sample between edges so the driver and monitor have settled
   task automatic drain_and_settle();
      while (queued_actions.size() != 0 || req_valid || predicted_status.size() != 0)
         @(negedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   // driver: offer queued items, hold while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) predicted_status.push_back(machine_advance(shown_item));
         if (queued_actions.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            shown_item = queued_actions.pop_front();
            req_valid <= 1'b1;
            req_action <= shown_item.action;
            req_rule_slot <= shown_item.slot;
            req_rule_state <= shown_item.rstate;
            req_rule_symbol <= shown_item.rsym;
            req_rule_next_state <= shown_item.rnext;
            req_rule_write <= shown_item.rwrite;
            req_rule_move <= shown_item.rmove;
            req_read_offset <= shown_item.offset;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall, with one long hold-off to back the block up
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_TICKS;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // monitor: compare each result beat with the oldest prediction
   always @(posedge clock) begin
      tm_status_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (predicted_status.size() == 0) begin
            $error("result beat with no prediction waiting");
            errors++;
         end else begin
            want = predicted_status.pop_front();
            check_field("halted", 32'(want.halted), 32'(rsp_halted));
            check_field("fault", 32'(want.fault), 32'(rsp_fault));
            check_field("current_state", 32'(want.state), 32'(rsp_current_state));
            check_field("step_count", want.steps, rsp_step_count);
            check_field("head_position", 32'(want.head), 32'(rsp_head_position));
            check_field("low_mark", 32'(want.low), 32'(rsp_low_mark));
            check_field("cell_char", 32'(want.ch), 32'(rsp_cell_char));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int base;
      int rc;
      int walk;
      logic [1:0] dir;
      ending_kind_type ending;
      for (int i = 0; i < TAPE_CELLS; i++) tm_tape[i] = '{written: 1'b0, sym: 1'b0};
      for (int i = 0; i < MAX_RULES; i++) tm_rules[i] = '0;
      tm_state = 8'd1;
      tm_head = 12'(TAPE_CELLS / 2);
      tm_low = 12'(TAPE_CELLS / 2);
      tm_steps = '0;
      tm_fault = FAULT_NONE;
      tm_rule_count = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // wait out the tape sweep
      while (req_stall) @(posedge clock);

      send_idle_pct = 10;
      recv_idle_pct = 58;
      write_rule_count(0);
      // fill the whole table; guards sit at the top for a count of MAX_RULES
      base = MAX_RULES - GUARD_RULES;
      for (int s = 0; s < MAX_RULES; s++) begin
         queued_actions.push_back(random_load(s, base));
         if (s % 8 == 7) begin
            queued_actions.push_back(random_item(base));
            // no steps yet: an empty scan would stop the machine for good
            if (queued_actions[$].action == ACT_STEP) queued_actions[$].action = ACT_READ;
         end
      end
      drain_and_settle();

      write_rule_count(MAX_RULES);
      queued_actions.push_back(make_item(ACT_LOAD, 0, 8'h01, 1'b0, 8'h2A, 1'b1, MOVE_RIGHT, 0));
      queued_actions.push_back(make_item(ACT_LOAD, 1, 8'h2A, 1'b0, 8'hD5, 1'b0, MOVE_ODD, 0));
      queued_actions.push_back(make_item(ACT_LOAD, 2, 8'hD5, 1'b0, 8'hFE, 1'b1, MOVE_LEFT, 0));
      queued_actions.push_back(make_item(ACT_LOAD, 3, 8'hFE, 1'b1, 8'hFF, 1'b0, MOVE_LEFT, 0));
      queued_actions.push_back(make_item(ACT_LOAD, 4, 8'hFF, 1'b0, 8'h01, 1'b1, MOVE_STAY, 0));
      repeat (5)
         queued_actions.push_back(make_item(ACT_STEP, 63, 8'hFF, 1'b1, 8'hFF, 1'b1, MOVE_LEFT,
                                            4095));
      queued_actions.push_back(make_item(ACT_READ, 0, 8'h00, 1'b0, 8'h00, 1'b0, MOVE_STAY, 0));
      queued_actions.push_back(make_item(ACT_READ, 0, 8'h00, 1'b0, 8'h00, 1'b0, MOVE_STAY, 1));
      queued_actions.push_back(make_item(ACT_READ, 0, 8'h00, 1'b0, 8'h00, 1'b0, MOVE_STAY, 2));
      queued_actions.push_back(make_item(ACT_READ, 0, 8'h00, 1'b0, 8'h00, 1'b0, MOVE_STAY, 3));
      queued_actions.push_back(make_item(ACT_READ, 0, 8'h00, 1'b0, 8'h00, 1'b0, MOVE_STAY, 4095));
      queued_actions.push_back(make_item(ACT_UNUSED, 63, 8'hFF, 1'b1, 8'hFF, 1'b1, MOVE_LEFT,
                                         4095));
      queued_actions.push_back(make_item(ACT_LOAD, 40, 8'h00, 1'b1, 8'h00, 1'b1, MOVE_ODD, 4095));
      queued_actions.push_back(make_item(ACT_LOAD, 41, 8'h80, 1'b0, 8'hFF, 1'b0, MOVE_STAY, 0));
      queued_actions.push_back(make_item(ACT_READ, 0, 8'h00, 1'b0, 8'h00, 1'b0, MOVE_STAY, 2048));
      queued_actions.push_back(make_item(ACT_STEP, 0, 8'h00, 1'b0, 8'h00, 1'b0, MOVE_STAY, 0));
      drain_and_settle();

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: rc = 127;
            1: rc = 10;
            2: rc = 37;
            3: rc = 65;
            4: rc = 20;
            default: rc = 64;
         endcase
         if (p >= 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else if (p >= 2) begin
            send_idle_pct = 58;
            recv_idle_pct = 10;
         end
         write_rule_count(rc);
         base = ((rc > MAX_RULES) ? MAX_RULES : rc) - GUARD_RULES;
         // move the guards to the top of the scanned slots
         for (int k = 0; k < GUARD_RULES; k++)
            queued_actions.push_back(guard_load(base + k, base));
         for (int n = 0; n < PHASE_ITEMS; n++) queued_actions.push_back(random_item(base));
         drain_and_settle();
      end

      // the machine can stop only once, so each run ends it one way
      ending = ending_kind_type'($urandom_range(0, 2));
      case (ending)
         END_HALT: begin
            queued_actions.push_back(make_item(ACT_LOAD, 0, tm_state, 1'b0, 8'h00, 1'b1,
                                               MOVE_RIGHT, 0));
            queued_actions.push_back(make_item(ACT_LOAD, 1, tm_state, 1'b1, 8'h00, 1'b0,
                                               MOVE_LEFT, 0));
            queued_actions.push_back(random_item(0));
            queued_actions.push_back(make_item(ACT_STEP, 0, 8'h00, 1'b0, 8'h00, 1'b0,
                                               MOVE_STAY, 0));
         end
         END_NOMATCH: begin
            write_rule_count(0);
            queued_actions.push_back(make_item(ACT_STEP, 0, 8'h00, 1'b0, 8'h00, 1'b0,
                                               MOVE_STAY, 0));
         end
         default: begin
            dir = $urandom_range(0, 1) ? MOVE_LEFT : MOVE_RIGHT;
            write_rule_count(GUARD_RULES);
            for (int k = 0; k < GUARD_RULES; k++) begin
               queued_actions.push_back(guard_load(k, 0));
               queued_actions[$].rmove = dir;
            end
            // walk one cell past the edge and a little more
            walk = (dir == MOVE_LEFT) ? int'(tm_head) + 4 : TAPE_CELLS - int'(tm_head) + 4;
            repeat (walk)
               queued_actions.push_back(make_item(ACT_STEP, 0, 8'h00, 1'b0, 8'h00, 1'b0,
                                                  MOVE_STAY, 0));
         end
      endcase
      for (int n = 0; n < 24; n++) queued_actions.push_back(random_item(0));
      drain_and_settle();
      repeat (2 * SETTLE_TICKS) @(posedge clock);

      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
